// ===== sv/pfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared codes, limits, types and helpers of the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

	// pixel layout codes
	localparam logic [2:0] FMT_GRAY = 3'd0;
	localparam logic [2:0] FMT_RGB  = 3'd1;
	localparam logic [2:0] FMT_BGR  = 3'd2;
	localparam logic [2:0] FMT_RGBA = 3'd3;
	localparam logic [2:0] FMT_ARGB = 3'd4;
	localparam logic [2:0] FMT_BGRA = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_SOURCE_FORMAT = 3'd0;
	localparam logic [2:0] REG_TARGET_FORMAT = 3'd1;
	localparam logic [2:0] REG_ROW_PIXELS    = 3'd2;
	localparam logic [2:0] REG_SOURCE_PITCH  = 3'd3;
	localparam logic [2:0] REG_IMAGE_ROWS    = 3'd4;

	// limits and constants
	localparam logic [12:0] MAX_ROW_PIXELS = 13'd4096;
	localparam logic [12:0] ROWS_LIMIT     = 13'd4096;
	localparam logic [7:0]  ALPHA_DEFAULT  = 8'hFF;
	// 683 / 2048 approximates 1/3 exactly for every sum up to 767
	localparam logic [9:0]  RECIP3         = 10'd683;
	localparam int          RECIP3_SHIFT   = 11;

	typedef logic [3:0][7:0] byte4_t;

	// one converted pixel as handed to the output buffer
	typedef struct packed {
		byte4_t     bytes;
		logic [2:0] count;
	} pix_out_t;

	// undefined codes act as gray
	function automatic logic [2:0] fmt_code(input logic [2:0] f);
		return (f > FMT_BGRA) ? FMT_GRAY : f;
	endfunction

	// bytes per pixel of a layout
	function automatic logic [2:0] pixel_size(input logic [2:0] f);
		logic [2:0] c;
		c = fmt_code(f);
		if (c == FMT_GRAY) return 3'd1;
		if (c <= FMT_BGR) return 3'd3;
		return 3'd4;
	endfunction

endpackage

// ===== sv/pfc_pixel_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pixel_map
// Reorders one gathered source pixel into the target layout, with gray mean.
// ----------------------------------------------------------------------------
module pfc_pixel_map (
	input  logic [2:0]        src_fmt,
	input  logic [2:0]        dst_fmt,
	input  pfc_pkg::byte4_t   src,
	output pfc_pkg::pix_out_t pix
);
	import pfc_pkg::*;

	logic [7:0]  r, g, b, a;
	logic [9:0]  sum;
	logic [19:0] prod;
	logic [7:0]  gray;

	// split source bytes into channels
	always_comb begin
		r = src[0];
		g = src[0];
		b = src[0];
		a = ALPHA_DEFAULT;
		unique case (src_fmt)
			FMT_GRAY: begin
				r = src[0]; g = src[0]; b = src[0];
			end
			FMT_RGB: begin
				r = src[0]; g = src[1]; b = src[2];
			end
			FMT_BGR: begin
				b = src[0]; g = src[1]; r = src[2];
			end
			FMT_RGBA: begin
				r = src[0]; g = src[1]; b = src[2]; a = src[3];
			end
			FMT_ARGB: begin
				a = src[0]; r = src[1]; g = src[2]; b = src[3];
			end
			default: begin
				b = src[0]; g = src[1]; r = src[2]; a = src[3];
			end
		endcase
	end

	// rounded mean of the colors, divide by three through a reciprocal
	assign sum  = {2'b00, r} + {2'b00, g} + {2'b00, b} + 10'd1;
	assign prod = {10'd0, sum} * {10'd0, RECIP3};
	assign gray = prod[RECIP3_SHIFT +: 8];

	// assemble target bytes
	always_comb begin
		pix.bytes = '0;
		pix.count = 3'd4;
		unique case (dst_fmt)
			FMT_GRAY: begin
				pix.bytes[0] = gray;
				pix.count    = 3'd1;
			end
			FMT_RGB: begin
				pix.bytes[0] = r; pix.bytes[1] = g; pix.bytes[2] = b;
				pix.count    = 3'd3;
			end
			FMT_BGR: begin
				pix.bytes[0] = b; pix.bytes[1] = g; pix.bytes[2] = r;
				pix.count    = 3'd3;
			end
			FMT_RGBA: begin
				pix.bytes[0] = r; pix.bytes[1] = g; pix.bytes[2] = b; pix.bytes[3] = a;
			end
			FMT_ARGB: begin
				pix.bytes[0] = a; pix.bytes[1] = r; pix.bytes[2] = g; pix.bytes[3] = b;
			end
			default: begin
				pix.bytes[0] = b; pix.bytes[1] = g; pix.bytes[2] = r; pix.bytes[3] = a;
			end
		endcase
	end

endmodule

// ===== sv/pixel_format_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_converter
// Gathers source pixels from a padded byte stream and emits packed pixels
// in the target layout, flagging pixel, row and image ends.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | in_byte
//  out     | out_valid/ out_ready | out_byte, pixel_done, row_done,
//          |                      | image_done
//  cfg     | cfg_we (no wait)     | cfg_idx, cfg_data
//
//  A completed pixel is converted in the same cycle that its last source byte
//  is taken, and lands in a 4-byte output buffer.
//  The output buffer drains one byte per cycle while out_ready is high, and
//  gathering of the next source pixel goes on while the buffer drains.
//  A pixel-completing byte waits while the buffer holds more than its final
//  byte, or holds only that byte and it is not taken in the same cycle;
//  padding and gathering bytes never wait.
//  Reset clears counters and held bytes, empties the buffer, and loads config
//  defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pixel_format_converter (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	// source bytes
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	// packed output bytes
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        pixel_done,
	output logic        row_done,
	output logic        image_done
);
	import pfc_pkg::*;

	// configuration registers
	logic [2:0]  source_format_q, target_format_q;
	logic [12:0] row_pixels_q, image_rows_q;
	logic [15:0] source_pitch_q;

	// gather and position state
	logic [1:0]  byte_phase_q;
	logic [2:0][7:0] held_q;
	logic [11:0] column_q, row_q;
	logic [15:0] padding_q;

	// output buffer
	byte4_t      obuf_q;
	logic [2:0]  ocnt_q;
	logic        row_end_q, img_end_q;

	logic [2:0]  sf, tf, sbpp;
	logic        completes, buf_free, in_fire, out_fire, load;
	logic [12:0] width_c, rows_c, col_inc, row_inc;
	logic        row_end, img_end;
	logic [14:0] used;
	logic [15:0] pad_next;
	byte4_t      src;
	pix_out_t    pix;
	logic [1:0]  held_idx;

	// config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_RGB;
			target_format_q <= FMT_RGB;
			row_pixels_q    <= 13'd1;
			source_pitch_q  <= 16'd3;
			image_rows_q    <= 13'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SOURCE_FORMAT: source_format_q <= cfg_data[2:0];
				REG_TARGET_FORMAT: target_format_q <= cfg_data[2:0];
				REG_ROW_PIXELS:    row_pixels_q    <= cfg_data[12:0];
				REG_SOURCE_PITCH:  source_pitch_q  <= cfg_data;
				REG_IMAGE_ROWS:    image_rows_q    <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// decoded config
	assign sf   = fmt_code(source_format_q);
	assign tf   = fmt_code(target_format_q);
	assign sbpp = pixel_size(sf);

	assign width_c = (row_pixels_q == 13'd0) ? 13'd1 :
		(row_pixels_q > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : row_pixels_q;
	assign rows_c  = (image_rows_q == 13'd0) ? 13'd1 :
		(image_rows_q > ROWS_LIMIT) ? ROWS_LIMIT : image_rows_q;

	// handshake
	assign completes = (padding_q == 16'd0) && ({1'b0, byte_phase_q} + 3'd1 >= sbpp);
	assign buf_free  = (ocnt_q == 3'd0) || ((ocnt_q == 3'd1) && out_ready);
	assign in_ready  = !completes || buf_free;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign load      = in_fire && completes;

	// source pixel assembly, current byte goes last
	always_comb begin
		src[0] = held_q[0];
		src[1] = held_q[1];
		src[2] = held_q[2];
		src[3] = 8'h00;
		case (sbpp)
			3'd1:    src[0] = in_byte;
			3'd3:    src[2] = in_byte;
			default: src[3] = in_byte;
		endcase
	end

	pfc_pixel_map u_map (
		.src_fmt (sf),
		.dst_fmt (tf),
		.src     (src),
		.pix     (pix)
	);

	// row and image end, padding for the next row
	assign col_inc = {1'b0, column_q} + 13'd1;
	assign row_inc = {1'b0, row_q} + 13'd1;
	assign row_end = col_inc >= width_c;
	assign img_end = row_end && (row_inc >= rows_c);

	always_comb begin
		case (sbpp)
			3'd1:    used = {2'b00, width_c};
			3'd3:    used = {1'b0, width_c, 1'b0} + {2'b00, width_c};
			default: used = {width_c, 2'b00};
		endcase
	end

	assign pad_next = (source_pitch_q > {1'b0, used}) ?
		(source_pitch_q - {1'b0, used}) : 16'd0;

	assign held_idx = (byte_phase_q == 2'd3) ? 2'd0 : byte_phase_q;

	// gather, padding and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_phase_q <= '0;
			held_q       <= '0;
			column_q     <= '0;
			row_q        <= '0;
			padding_q    <= '0;
		end else if (in_fire) begin
			if (padding_q != 16'd0) begin
				padding_q <= padding_q - 16'd1;
			end else if (!completes) begin
				held_q[held_idx] <= in_byte;
				byte_phase_q     <= byte_phase_q + 2'd1;
			end else begin
				byte_phase_q <= '0;
				if (row_end) begin
					column_q  <= '0;
					padding_q <= pad_next;
					row_q     <= img_end ? 12'd0 : row_inc[11:0];
				end else begin
					column_q <= col_inc[11:0];
				end
			end
		end
	end

	// output buffer, shifts one byte out per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q    <= '0;
			row_end_q <= 1'b0;
			img_end_q <= 1'b0;
		end else if (load) begin
			ocnt_q    <= pix.count;
			row_end_q <= row_end;
			img_end_q <= img_end;
		end else if (out_fire) begin
			ocnt_q <= ocnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obuf_q <= pix.bytes;
		end else if (out_fire) begin
			obuf_q <= {8'h00, obuf_q[3], obuf_q[2], obuf_q[1]};
		end
	end

	assign out_valid  = ocnt_q != 3'd0;
	assign out_byte   = obuf_q[0];
	assign pixel_done = ocnt_q == 3'd1;
	assign row_done   = pixel_done && row_end_q;
	assign image_done = pixel_done && img_end_q;

	// checks
	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 3'd4)
		else $error("output buffer count out of range");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("completed pixel not presented");

	a_pad_swallow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && padding_q != 16'd0) |=> (padding_q == $past(padding_q) - 16'd1)
			&& (byte_phase_q == $past(byte_phase_q)))
		else $error("padding byte not swallowed");

	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && image_done) |-> (row_done && pixel_done))
		else $error("image end without row end");

endmodule
